FILE: rtl/imufs_pkg.sv
package imufs_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int POS_W   = 6;
    localparam int IDX_W   = 4;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

    localparam int NUM_FIELDS = 14;

    localparam logic [POS_W-1:0] POS_ID         = 6'd0;
    localparam logic [POS_W-1:0] POS_TIMER_LO   = 6'd4;
    localparam logic [POS_W-1:0] POS_READ_FIRST = 6'd10;
    localparam logic [POS_W-1:0] POS_READ_LAST  = 6'd32;

    localparam logic [IDX_W-1:0] FLD_ID         = 4'd0;
    localparam logic [IDX_W-1:0] FLD_TIMER      = 4'd1;
    localparam logic [IDX_W-1:0] FLD_READ_FIRST = 4'd2;
    localparam logic [IDX_W-1:0] FLD_LAST       = 4'd13;

    typedef struct packed {
        logic              init_sum;
        logic              frame_byte;
        logic [POS_W-1:0]  pos;
        logic              finish;
        logic              late;
        logic              emit_load;
        logic [IDX_W-1:0]  emit_idx;
        logic              emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic sync_byte;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: rtl/imu_frame_sync_deframer.sv
// channel  direction  handshake            payload
// input    in         in_valid / in_ready  rx_byte
// output   out        out_valid/out_ready  field_index, raw_value, checksum_ok,
//                                          late_sync, last_of_frame
//
// one byte per cycle is taken while hunting for sync and while collecting a frame
// the byte ending a frame starts a burst of 14 results, one per cycle at best;
// in_ready stays low until the last result is loaded in the output register
// a frame is FRAME_LEN bytes after SYNC_LEN sync bytes; its results go out
// through the single result register
// output stalls hold the burst; reset (rst_n, async, active low) starts a hunt
module imu_frame_sync_deframer #(
    parameter int SYNC_LEN  = 4,
    parameter int FRAME_LEN = 34
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [imufs_pkg::BYTE_W-1:0]        rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [imufs_pkg::IDX_W-1:0]         field_index,
    output logic [imufs_pkg::WORD_W-1:0]        raw_value,
    output logic                                checksum_ok,
    output logic                                late_sync,
    output logic                                last_of_frame
);
    import imufs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    imufs_ctrl #(
        .SYNC_LEN  (SYNC_LEN),
        .FRAME_LEN (FRAME_LEN)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    imufs_dp #(
        .SYNC_LEN (SYNC_LEN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx_byte),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .field_index   (field_index),
        .raw_value     (raw_value),
        .checksum_ok   (checksum_ok),
        .late_sync     (late_sync),
        .last_of_frame (last_of_frame)
    );

endmodule

FILE: rtl/imufs_ctrl.sv
module imufs_ctrl #(
    parameter int SYNC_LEN  = 4,
    parameter int FRAME_LEN = 34
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  imufs_pkg::dp_status_t status,
    output imufs_pkg::dp_cmd_t    cmd
);
    import imufs_pkg::*;

    localparam int FF_W = $clog2(SYNC_LEN + 1);

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_FRAME,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [FF_W-1:0]   ff_run_reg, ff_run_next;
    logic              late_reg, late_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  emit_reg, emit_next;
    logic              accept;
    logic [FF_W-1:0]   ff_inc;

    assign in_ready = (state_reg != ST_EMIT);
    assign accept   = in_valid && in_ready;
    assign ff_inc   = status.sync_byte ? ff_run_reg + FF_W'(1) : '0;

    always_comb
    begin
        state_next  = state_reg;
        ff_run_next = ff_run_reg;
        late_next   = late_reg;
        pos_next    = pos_reg;
        emit_next   = emit_reg;

        cmd           = '0;
        cmd.pos       = pos_reg;
        cmd.late      = late_reg;
        cmd.emit_idx  = emit_reg;
        cmd.emit_last = (emit_reg == FLD_LAST);

        case (state_reg)
            ST_HUNT:
            begin
                if (accept)
                begin
                    ff_run_next = ff_inc;
                    if (!status.sync_byte)
                    begin
                        late_next = 1'b1;
                    end
                    if (ff_inc >= FF_W'(SYNC_LEN))
                    begin
                        cmd.init_sum = 1'b1;
                        pos_next     = '0;
                        state_next   = ST_FRAME;
                    end
                end
            end
            ST_FRAME:
            begin
                if (accept)
                begin
                    if (pos_reg < POS_W'(FRAME_LEN - 1))
                    begin
                        cmd.frame_byte = 1'b1;
                        pos_next       = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        cmd.finish  = 1'b1;
                        ff_run_next = '0;
                        late_next   = 1'b0;
                        pos_next    = '0;
                        emit_next   = FLD_ID;
                        state_next  = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_load = 1'b1;
                    if (emit_reg == FLD_LAST)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        emit_next = emit_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HUNT;
            ff_run_reg <= '0;
            late_reg   <= 1'b0;
            pos_reg    <= '0;
            emit_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ff_run_reg <= ff_run_next;
            late_reg   <= late_next;
            pos_reg    <= pos_next;
            emit_reg   <= emit_next;
        end
    end

endmodule

FILE: rtl/imufs_dp.sv
module imufs_dp #(
    parameter int SYNC_LEN = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [imufs_pkg::BYTE_W-1:0]        rx_byte,
    input  imufs_pkg::dp_cmd_t                  cmd,
    output imufs_pkg::dp_status_t               status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [imufs_pkg::IDX_W-1:0]         field_index,
    output logic [imufs_pkg::WORD_W-1:0]        raw_value,
    output logic                                checksum_ok,
    output logic                                late_sync,
    output logic                                last_of_frame
);
    import imufs_pkg::*;

    localparam logic [BYTE_W-1:0] SUM_INIT = BYTE_W'((SYNC_LEN * 255) % 256);

    logic [BYTE_W-1:0]  sum_reg;
    logic [BYTE_W-1:0]  hold_reg;
    logic [WORD_W-1:0]  store_reg [NUM_FIELDS];
    logic               ok_reg;
    logic               late_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [WORD_W-1:0]  value_reg;
    logic               ok_out_reg;
    logic               late_out_reg;
    logic               last_reg;

    logic [POS_W-1:0]   rel;
    logic [IDX_W-1:0]   read_idx;
    logic               is_read;
    logic [WORD_W-1:0]  word;

    assign status = '{sync_byte: (rx_byte == SYNC_BYTE),
                      out_busy:  (out_valid_reg && !out_ready)};

    assign rel      = cmd.pos - POS_READ_FIRST;
    assign read_idx = FLD_READ_FIRST + IDX_W'(rel[POS_W-1:1]);
    assign is_read  = (cmd.pos >= POS_READ_FIRST) && (cmd.pos <= POS_READ_LAST)
                      && !cmd.pos[0];
    assign word     = {hold_reg, rx_byte};

    // frame capture and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            hold_reg <= '0;
        end
        else
        begin
            if (cmd.init_sum)
            begin
                sum_reg <= SUM_INIT;
            end
            else if (cmd.frame_byte)
            begin
                sum_reg <= sum_reg + rx_byte;
                if (cmd.pos != POS_ID && cmd.pos != POS_TIMER_LO && !is_read
                    && cmd.pos[0])
                begin
                    hold_reg <= rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_byte)
        begin
            if (cmd.pos == POS_ID)
            begin
                store_reg[FLD_ID] <= {{(WORD_W-BYTE_W){1'b0}}, rx_byte};
            end
            else if (cmd.pos == POS_TIMER_LO)
            begin
                store_reg[FLD_TIMER] <= word;
            end
            else if (is_read)
            begin
                store_reg[read_idx] <= word;
            end
        end
        if (cmd.finish)
        begin
            ok_reg   <= (rx_byte == sum_reg);
            late_reg <= cmd.late;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            idx_reg      <= cmd.emit_idx;
            value_reg    <= store_reg[cmd.emit_idx];
            ok_out_reg   <= ok_reg;
            late_out_reg <= late_reg;
            last_reg     <= cmd.emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign field_index   = idx_reg;
    assign raw_value     = value_reg;
    assign checksum_ok   = ok_out_reg;
    assign late_sync     = late_out_reg;
    assign last_of_frame = last_reg;

endmodule
